// File: hw/rtl/modular_inverse_ext_euclid_top_assert.svh
// Assertion macros for the modular inverse block.
// Used by the checker bound to modular_inverse_ext_euclid_top.
`ifndef MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH
`define MODULAR_INVERSE_EXT_EUCLID_TOP_ASSERT_SVH

// same-cycle implication, reset masks it
`define MINV_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masks it
`define MINV_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/minv_pkg.sv
// Shared constants and types for the modular inverse block.
// No dependencies.
package minv_pkg;

	localparam int MINV_DATA_WIDTH = 32;
	localparam logic [31:0] MINV_MOD_RESET = 32'd65521;

	typedef struct packed {
		logic idle;
		logic done;
		logic zero_input;
	} minv_stat_t;

endpackage

// File: hw/rtl/minv_core.sv
// Extended Euclid sequencer: bit-serial shift-subtract division with the
// s coefficient updated alongside. Depends on minv_pkg.
module minv_core
	import minv_pkg::*;
#(
	parameter int DATA_WIDTH = MINV_DATA_WIDTH,
	localparam int OP_W = DATA_WIDTH - 1,
	localparam int S_W = DATA_WIDTH + 2,
	localparam int K_W = $clog2(OP_W)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [OP_W-1:0] value,
	input  logic [OP_W-1:0] modulus,
	input  logic            take,
	output minv_stat_t      stat,
	output logic [OP_W-1:0] inverse
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_REDUCE,
		ST_FIX,
		ST_DONE
	} state_t;

	state_t                 state_q;
	logic [OP_W-1:0]        a_q;
	logic [OP_W-1:0]        b_q;
	logic signed [S_W-1:0]  sa_q;
	logic signed [S_W-1:0]  sb_q;
	logic [K_W-1:0]         k_q;
	logic [OP_W-1:0]        mod_q;
	logic                   zero_q;

	logic [OP_W:0]          b_dbl;
	logic                   fits;
	logic                   ge;
	logic [OP_W-1:0]        a_nx;
	logic signed [S_W-1:0]  sa_nx;
	logic signed [S_W-1:0]  mod_ext;
	logic signed [S_W-1:0]  sa_fix;

	assign b_dbl   = {b_q, 1'b0};
	assign fits    = b_dbl <= {1'b0, a_q};
	assign ge      = b_q <= a_q;
	assign a_nx    = ge ? (a_q - b_q) : a_q;
	assign sa_nx   = ge ? (sa_q - sb_q) : sa_q;
	assign mod_ext = signed'({{(S_W - OP_W){1'b0}}, mod_q});

	always_comb begin
		if (sa_q < 0) begin
			sa_fix = sa_q + mod_ext;
		end else if (sa_q > mod_ext) begin
			sa_fix = sa_q - mod_ext;
		end else begin
			sa_fix = sa_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						zero_q <= (value == '0);
						mod_q  <= modulus;
						a_q    <= value;
						b_q    <= modulus;
						sb_q   <= '0;
						k_q    <= '0;
						if (value == '0) begin
							sa_q    <= '0;
							state_q <= ST_DONE;
						end else if (value == OP_W'(1)) begin
							sa_q    <= S_W'(1);
							state_q <= ST_DONE;
						end else begin
							sa_q    <= S_W'(1);
							state_q <= (modulus == '0) ? ST_FIX : ST_ALIGN;
						end
					end
				end
				ST_ALIGN: begin
					if (fits) begin
						b_q  <= b_dbl[OP_W-1:0];
						sb_q <= sb_q <<< 1;
						k_q  <= k_q + K_W'(1);
					end else begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (k_q == '0) begin
						// quotient complete: rotate (prev, cur)
						a_q     <= b_q;
						b_q     <= a_nx;
						sa_q    <= sb_q;
						sb_q    <= sa_nx;
						state_q <= (a_nx == '0) ? ST_FIX : ST_ALIGN;
					end else begin
						a_q  <= a_nx;
						sa_q <= sa_nx;
						b_q  <= b_q >> 1;
						sb_q <= sb_q >>> 1;
						k_q  <= k_q - K_W'(1);
					end
				end
				ST_FIX: begin
					sa_q    <= sa_fix;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign stat.idle       = (state_q == ST_IDLE);
	assign stat.done       = (state_q == ST_DONE);
	assign stat.zero_input = zero_q;
	assign inverse         = sa_q[OP_W-1:0];

endmodule

// File: hw/rtl/modular_inverse_ext_euclid_top.sv
// Modular inverse by extended Euclid: one item in, its inverse modulo the
// configured modulus out. A value of 0 or 1 skips the Euclid loop; any other
// value runs the bit-serial shift-subtract loop in minv_core, whose work per
// Euclid step grows with that step's quotient, one quotient bit per cycle.
// The result sits in an output register, so the next item is taken while it
// waits. A zero value returns 0 with the zero flag set in m_tuser. Depends on
// minv_pkg, minv_core.
module modular_inverse_ext_euclid_top
	import minv_pkg::*;
#(
	parameter int DATA_WIDTH = MINV_DATA_WIDTH,
	localparam int OP_W = DATA_WIDTH - 1,
	localparam int TD_W = ((OP_W + 7) / 8) * 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [OP_W-1:0] cfg_data,   // modulus
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [TD_W-1:0] s_tdata,    // value, zero pad above
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [TD_W-1:0] m_tdata,    // inverse, zero pad above
	output logic            m_tuser     // zero_input
);

	logic [OP_W-1:0] modulus_q;
	logic            out_valid_q;
	logic [OP_W-1:0] out_inv_q;
	logic            out_zero_q;

	minv_stat_t      stat;
	logic [OP_W-1:0] core_inv;
	logic            start;
	logic            take;

	assign cfg_ready = 1'b1;
	assign s_tready  = stat.idle;
	assign start     = s_tvalid && stat.idle;
	assign take      = stat.done && (!out_valid_q || m_tready);

	minv_core #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.value   (s_tdata[OP_W-1:0]),
		.modulus (modulus_q),
		.take    (take),
		.stat    (stat),
		.inverse (core_inv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MINV_MOD_RESET[OP_W-1:0];
		end else if (cfg_valid) begin
			modulus_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_inv_q  <= core_inv;
			out_zero_q <= stat.zero_input;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TD_W - OP_W){1'b0}}, out_inv_q};
	assign m_tuser  = out_zero_q;

endmodule

// File: hw/rtl/minv_chk.sv
// Port-level checker for modular_inverse_ext_euclid_top, bound to it below.
// Depends on minv_pkg and modular_inverse_ext_euclid_top_assert.svh.
`include "modular_inverse_ext_euclid_top_assert.svh"

module minv_chk
	import minv_pkg::*;
#(
	parameter int DATA_WIDTH = MINV_DATA_WIDTH,
	localparam int OP_W = DATA_WIDTH - 1,
	localparam int TD_W = ((OP_W + 7) / 8) * 8
) (
	input logic            clk,
	input logic            arst_n,
	input logic            s_tvalid,
	input logic            s_tready,
	input logic [TD_W-1:0] s_tdata,
	input logic            m_tvalid,
	input logic            m_tready,
	input logic [TD_W-1:0] m_tdata,
	input logic            m_tuser
);

	logic s_acc;
	logic m_stall;
	logic zero_in;

	assign s_acc   = s_tvalid && s_tready;
	assign m_stall = m_tvalid && !m_tready;
	assign zero_in = (s_tdata[OP_W-1:0] == '0);

	`MINV_ASSERT_NEXT(a_out_hold, clk, arst_n, m_stall,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output changed while stalled")

	`MINV_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, s_acc, !s_tready,
		"input taken while an item is in work")

	`MINV_ASSERT_NOW(a_zero_result, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0,
		"zero flag with nonzero inverse")

	`MINV_ASSERT_NEXT(a_zero_busy, clk, arst_n, s_acc && zero_in,
		!s_tready, "zero item not held in work")

endmodule

bind modular_inverse_ext_euclid_top minv_chk #(
	.DATA_WIDTH (DATA_WIDTH)
) u_minv_chk (.*);
